// ===== src/window_median_filter_core_defines.svh =====
// Assertion macros for the window median filter RTL.
// Used by files that carry concurrent assertions; no other dependencies.
`ifndef WINDOW_MEDIAN_FILTER_CORE_DEFINES_SVH
`define WINDOW_MEDIAN_FILTER_CORE_DEFINES_SVH
`ifndef ASSERT_OFF
`define WMF_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define WMF_ASSERT_ALWAYS(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define WMF_ASSERT(lbl, clk, rst, prop, msg)
`define WMF_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif
`endif

// ===== src/wmf_pkg.sv =====
// Shared types and constants of the window median filter.
// No dependencies.
`default_nettype none
package wmf_pkg;
   localparam int PIXEL_W    = 8;
   localparam int ROW_W      = 12;
   localparam int COL_W      = 10;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 13;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_IMAGE_WIDTH  = 2'd0,
      CSR_IMAGE_HEIGHT = 2'd1,
      CSR_WINDOW_HALF  = 2'd2,
      CSR_UNUSED       = 2'd3
   } csr_idx_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_LOAD,
      ST_MED_A,
      ST_MED_B,
      ST_OUT
   } state_type;
endpackage
`default_nettype wire

// ===== src/wmf_if.sv =====
// Channel interfaces of the window median filter: pixel in, result out, register write.
// Depends on wmf_pkg.
`default_nettype none
interface wmf_req_if import wmf_pkg::*; ();
   logic               valid;
   logic               ready;
   logic [PIXEL_W-1:0] pixel;
   modport source (output valid, output pixel, input ready);
   modport sink (input valid, input pixel, output ready);
endinterface

interface wmf_rsp_if import wmf_pkg::*; ();
   logic               valid;
   logic               ready;
   logic [PIXEL_W-1:0] median;
   logic [ROW_W-1:0]   row;
   logic [COL_W-1:0]   col;
   logic               last;
   modport source (output valid, output median, output row, output col, output last,
      input ready);
   modport sink (input valid, input median, input row, input col, input last,
      output ready);
endinterface

interface wmf_csr_if import wmf_pkg::*; ();
   logic                  valid;
   logic                  ready;
   logic [CSR_IDX_W-1:0]  index;
   logic [CSR_DATA_W-1:0] data;
   modport source (output valid, output index, output data, input ready);
   modport sink (input valid, input index, input data, output ready);
endinterface
`default_nettype wire

// ===== src/wmf_line_store.sv =====
// One row slot of the line store: a single-port read-first memory.
// Depends on wmf_pkg.
`default_nettype none
module wmf_line_store
   import wmf_pkg::*;
#(
   parameter int DEPTH = 1024
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] addr,
   input  wire logic [PIXEL_W-1:0]       wr_data,
   output logic      [PIXEL_W-1:0]       rd_data
);
   logic [PIXEL_W-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      rd_data <= mem[addr];
      if (wr_en) begin
         mem[addr] <= wr_data;
      end
   end
endmodule
`default_nettype wire

// ===== src/wmf_cell.sv =====
// One window column cell: holds a column of pixels, shifts toward its neighbor,
// counts its active pixels at or below a threshold. Depends on wmf_pkg.
`default_nettype none
module wmf_cell
   import wmf_pkg::*;
#(
   parameter int SIDE = 9
) (
   input  wire logic                          clock,
   input  wire logic                          shift_en,
   input  wire logic [SIDE-1:0][PIXEL_W-1:0]  col_in,
   input  wire logic [SIDE-1:0]               row_en,
   input  wire logic [PIXEL_W-1:0]            thresh,
   output logic      [SIDE-1:0][PIXEL_W-1:0]  col_out,
   output logic      [$clog2(SIDE+1)-1:0]     count_out
);
   localparam int CNT_W = $clog2(SIDE + 1);

   logic [SIDE-1:0][PIXEL_W-1:0] pix_ff;
   logic [CNT_W-1:0]             cnt_in;
   logic [CNT_W-1:0]             cnt_ff;

   always_comb begin
      cnt_in = '0;
      for (int i = 0; i < SIDE; i++) begin
         if (row_en[i] && (pix_ff[i] <= thresh)) begin
            cnt_in = cnt_in + CNT_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (shift_en) begin
         pix_ff <= col_in;
      end
      cnt_ff <= cnt_in;
   end

   assign col_out   = pix_ff;
   assign count_out = cnt_ff;
endmodule
`default_nettype wire

// ===== src/window_median_filter_core.sv =====
// Window median filter: a border pixel is only loaded; an interior pixel is loaded,
// searched bitwise over the cells in 8 threshold steps (ST_MED_A, ST_MED_B), held
// in ST_OUT until rsp is ready; no new pixel is taken meanwhile. This search sets the rate.
// Synchronous active-high reset: registers to 640 x 480, h = 1, counters to zero.
// Line store content is undefined until written; no clearing pass.
`default_nettype none
`include "window_median_filter_core_defines.svh"
module window_median_filter_core
   import wmf_pkg::*;
#(
   parameter int MAX_WIDTH  = 1024,
   parameter int MAX_HEIGHT = 4096,
   parameter int MAX_HALF   = 4
) (
   input wire logic clock,
   input wire logic reset,
   wmf_req_if.sink   req_ch,
   wmf_rsp_if.source rsp_ch,
   wmf_csr_if.sink   csr_ch
);
   localparam int SIDE   = 2 * MAX_HALF + 1;
   localparam int NSLOT  = 2 * MAX_HALF;
   localparam int CW     = $clog2(MAX_WIDTH);
   localparam int WW     = $clog2(MAX_WIDTH + 1);
   localparam int RW     = $clog2(MAX_HEIGHT);
   localparam int HTW    = $clog2(MAX_HEIGHT + 1);
   localparam int HW     = $clog2(MAX_HALF + 1);
   localparam int SW     = $clog2(NSLOT);
   localparam int CNT_W  = $clog2(SIDE + 1);
   localparam int SUM_W  = $clog2(SIDE * SIDE + 1);

   state_type state_ff, state_in;

   logic [WW-1:0]  width_ff;
   logic [HTW-1:0] height_ff;
   logic [HW-1:0]  half_ff;
   logic [CW-1:0]  col_ff;
   logic [RW-1:0]  row_ff;
   logic [SW-1:0]  slot_ff;
   logic [SW-1:0]  rslot_ff;

   logic [PIXEL_W-1:0] px_ff;
   logic               emit_ff;
   logic [ROW_W-1:0]   orow_ff;
   logic [COL_W-1:0]   ocol_ff;
   logic               last_ff;
   logic [PIXEL_W-1:0] res_ff, res_in;
   logic [2:0]         bit_ff;

   logic            req_xfer, csr_xfer;
   logic [SW:0]     nslot;
   logic [SW:0]     slot_inc;
   logic [31:0]     csr_val;
   logic            shift_en;
   logic            interior;
   logic            col_wrap;
   logic            row_wrap;
   logic [PIXEL_W-1:0] thresh;
   logic [SUM_W-1:0]   sum;
   logic [SUM_W-1:0]   rank;

   logic [NSLOT-1:0][PIXEL_W-1:0] rd_data;
   logic [SIDE-1:0][PIXEL_W-1:0]  new_col;
   logic [SIDE-1:0]               row_en;
   logic [SIDE:0][SIDE-1:0][PIXEL_W-1:0] chain;
   logic [SIDE-1:0][CNT_W-1:0]    cell_cnt;

   assign req_xfer = req_ch.valid && req_ch.ready;
   assign csr_xfer = csr_ch.valid && csr_ch.ready;
   assign nslot    = (SW + 1)'({half_ff, 1'b0});
   assign slot_inc = (SW + 1)'(slot_ff) + (SW + 1)'(1);
   assign csr_val  = 32'(csr_ch.data);
   assign interior = (32'(row_ff) >= 32'(nslot)) && (32'(col_ff) >= 32'(nslot));
   assign col_wrap = (32'(col_ff) + 32'd1) >= 32'(width_ff);
   assign row_wrap = (32'(row_ff) + 32'd1) >= 32'(height_ff);
   assign rank     = SUM_W'(32'd2 * 32'(half_ff) * (32'(half_ff) + 32'd1));
   assign thresh   = res_ff | ((PIXEL_W'(1) << bit_ff) - PIXEL_W'(1));

   for (genvar k = 0; k < NSLOT; k++) begin : g_store
      wmf_line_store #(.DEPTH(MAX_WIDTH)) u_store (
         .clock   (clock),
         .wr_en   (req_xfer && (slot_ff == SW'(k))),
         .addr    (col_ff),
         .wr_data (req_ch.pixel),
         .rd_data (rd_data[k])
      );
   end

   always_comb begin
      logic [SW:0] idx;
      idx = '0;
      for (int i = 0; i < SIDE; i++) begin
         row_en[i]  = 32'(i) <= 32'(nslot);
         new_col[i] = '0;
         if (32'(i) < 32'(nslot)) begin
            idx = (SW + 1)'(rslot_ff) + (SW + 1)'(i);
            if (idx >= nslot) begin
               idx = idx - nslot;
            end
            new_col[i] = rd_data[idx[SW-1:0]];
         end else if (32'(i) == 32'(nslot)) begin
            new_col[i] = px_ff;
         end
      end
   end

   assign chain[SIDE] = new_col;
   for (genvar j = 0; j < SIDE; j++) begin : g_cell
      wmf_cell #(.SIDE(SIDE)) u_cell (
         .clock     (clock),
         .shift_en  (shift_en),
         .col_in    ((32'(j) == 32'(nslot)) ? new_col : chain[j+1]),
         .row_en    (row_en),
         .thresh    (thresh),
         .col_out   (chain[j]),
         .count_out (cell_cnt[j])
      );
   end

   always_comb begin
      sum = '0;
      for (int j = 0; j < SIDE; j++) begin
         if (32'(j) <= 32'(nslot)) begin
            sum = sum + SUM_W'(cell_cnt[j]);
         end
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_xfer) begin
               state_in = ST_LOAD;
            end
         end
         ST_LOAD: state_in = emit_ff ? ST_MED_A : ST_IDLE;
         ST_MED_A: state_in = ST_MED_B;
         ST_MED_B: state_in = (bit_ff == 3'd0) ? ST_OUT : ST_MED_A;
         ST_OUT: begin
            if (rsp_ch.ready) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      req_ch.ready = 1'b0;
      csr_ch.ready = 1'b0;
      rsp_ch.valid = 1'b0;
      shift_en     = 1'b0;
      res_in       = res_ff;
      case (state_ff)
         ST_IDLE: begin
            req_ch.ready = !csr_ch.valid;
            csr_ch.ready = 1'b1;
         end
         ST_LOAD: shift_en = 1'b1;
         ST_MED_B: begin
            if (sum <= rank) begin
               res_in = res_ff | (PIXEL_W'(1) << bit_ff);
            end
         end
         ST_OUT: rsp_ch.valid = 1'b1;
         default: begin
            res_in = res_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         width_ff  <= WW'(640 > MAX_WIDTH ? MAX_WIDTH : 640);
         height_ff <= HTW'(480 > MAX_HEIGHT ? MAX_HEIGHT : 480);
         half_ff   <= HW'(1);
         col_ff    <= '0;
         row_ff    <= '0;
         slot_ff   <= '0;
      end else begin
         state_ff <= state_in;
         if (csr_xfer) begin
            if (csr_idx_type'(csr_ch.index) inside {CSR_IMAGE_WIDTH, CSR_IMAGE_HEIGHT,
                  CSR_WINDOW_HALF}) begin
               col_ff  <= '0;
               row_ff  <= '0;
               slot_ff <= '0;
            end
            case (csr_idx_type'(csr_ch.index))
               CSR_IMAGE_WIDTH: begin
                  width_ff <= (csr_val < 32'd1) ? WW'(1) :
                     (csr_val > 32'(MAX_WIDTH)) ? WW'(MAX_WIDTH) : WW'(csr_val);
               end
               CSR_IMAGE_HEIGHT: begin
                  height_ff <= (csr_val < 32'd1) ? HTW'(1) :
                     (csr_val > 32'(MAX_HEIGHT)) ? HTW'(MAX_HEIGHT) : HTW'(csr_val);
               end
               CSR_WINDOW_HALF: begin
                  half_ff <= (csr_val < 32'd1) ? HW'(1) :
                     (csr_val > 32'(MAX_HALF)) ? HW'(MAX_HALF) : HW'(csr_val);
               end
               default: begin
                  width_ff <= width_ff;
               end
            endcase
         end else if (req_xfer) begin
            if (col_wrap) begin
               col_ff <= '0;
               if (row_wrap) begin
                  row_ff  <= '0;
                  slot_ff <= '0;
               end else begin
                  row_ff  <= row_ff + RW'(1);
                  slot_ff <= (slot_inc >= nslot) ? '0 : slot_inc[SW-1:0];
               end
            end else begin
               col_ff <= col_ff + CW'(1);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_xfer) begin
         px_ff    <= req_ch.pixel;
         rslot_ff <= slot_ff;
         emit_ff  <= interior;
         orow_ff  <= ROW_W'(32'(row_ff) - 32'(half_ff));
         ocol_ff  <= COL_W'(32'(col_ff) - 32'(half_ff));
         last_ff  <= ((32'(row_ff) + 32'd1) == 32'(height_ff)) &&
                     ((32'(col_ff) + 32'd1) == 32'(width_ff));
      end
      if (state_ff == ST_LOAD) begin
         res_ff <= '0;
         bit_ff <= 3'd7;
      end else if (state_ff == ST_MED_B) begin
         res_ff <= res_in;
         bit_ff <= bit_ff - 3'd1;
      end
   end

   assign rsp_ch.median = res_ff;
   assign rsp_ch.row    = orow_ff;
   assign rsp_ch.col    = ocol_ff;
   assign rsp_ch.last   = last_ff;

   `WMF_ASSERT(a_req_to_load, clock, reset, req_xfer |=> (state_ff == ST_LOAD), "accepted pixel did not load")
   `WMF_ASSERT(a_no_overlap, clock, reset, !(req_ch.ready && rsp_ch.valid), "input taken while result pending")
   `WMF_ASSERT(a_slot_range, clock, reset, (32'(slot_ff) < 32'(nslot)), "line slot out of range")
   `WMF_ASSERT(a_csr_idle, clock, reset, csr_xfer |-> (state_ff == ST_IDLE), "register write while busy")
endmodule
`default_nettype wire

// ===== test/wmf_tb_if.sv =====
`timescale 1ns / 1ps
// Testbench package: the packed result record compared by the checker.
// Depends on wmf_pkg.
package wmf_tb_pkg;
   import wmf_pkg::*;
   typedef struct packed {
      logic [PIXEL_W-1:0] median;
      logic [ROW_W-1:0]   row;
      logic [COL_W-1:0]   col;
      logic               last;
   } filt_result_type;
endpackage

// ===== test/testbench.sv =====
`timescale 1ns / 1ps
// Testbench of window_median_filter_core: streams raster frames through the filter,
// predicts each median, row, col and last flag, and compares every result transfer.
// Depends on wmf_pkg, wmf_if and wmf_tb_pkg.
module testbench;
   import wmf_pkg::*;
   import wmf_tb_pkg::*;

   localparam int MAXW = 1024;
   localparam int MAXH = 4096;
   localparam int MAXHALF = 4;
   localparam int SIDE_MAX = 2 * MAXHALF + 1;
   localparam int WD_LIMIT = 20000;

   logic clock;
   logic reset;
   wmf_req_if req_ch ();
   wmf_rsp_if rsp_ch ();
   wmf_csr_if csr_ch ();

   window_median_filter_core dut (
      .clock(clock), .reset(reset), .req_ch(req_ch), .rsp_ch(rsp_ch), .csr_ch(csr_ch)
   );

   int unsigned img_w, img_h, half;
   logic [7:0] lines [2*MAXHALF*MAXW];
   logic [7:0] win [SIDE_MAX][SIDE_MAX];
   int unsigned cur_col, cur_row;
   filt_result_type expected_q[$];
   int mismatches, results_seen, pixels_sent, idle_count;
   bit rsp_idle_en, req_idle_en, long_hold;

   initial begin
      clock = 0;
      forever #5 clock = ~clock;
   end

   function automatic int unsigned clamp_val(int unsigned v, int unsigned hi);
      if (v < 1) return 1;
      if (v > hi) return hi;
      return v;
   endfunction

   function automatic logic [7:0] window_rank(int unsigned side);
      int unsigned hist[256];
      int unsigned acc;
      acc = 0;
      foreach (hist[k]) hist[k] = 0;
      for (int i = 0; i < side; i++)
         for (int j = 0; j < side; j++) hist[win[i][j]]++;
      for (int k = 0; k < 256; k++) begin
         acc += hist[k];
         if (acc > (side * side) / 2) return k[7:0];
      end
      return 8'hff;
   endfunction

   task automatic predict_pixel(logic [7:0] px);
      int unsigned side, nslots, r, c;
      filt_result_type res;
      side = 2 * half + 1;
      nslots = 2 * half;
      r = cur_row;
      c = cur_col;
      if (c >= MAXW) c = MAXW - 1;
      for (int i = 0; i < side; i++)
         for (int j = 0; j + 1 < side; j++) win[i][j] = win[i][j+1];
      for (int i = 0; i < nslots; i++)
         win[i][side-1] = lines[((r + i) % nslots) * MAXW + c];
      win[nslots][side-1] = px;
      lines[(r % nslots) * MAXW + c] = px;
      if (r >= nslots && c >= nslots) begin
         res.median = window_rank(side);
         res.row = ROW_W'(r - half);
         res.col = COL_W'(c - half);
         res.last = (r + 1 == img_h && c + 1 == img_w);
         expected_q.push_back(res);
      end
      c++;
      if (c >= img_w) begin
         c = 0;
         r++;
         if (r >= img_h) r = 0;
      end
      cur_col = c;
      cur_row = r;
   endtask

   task automatic send_pixel(logic [7:0] px);
      if (req_idle_en && $urandom_range(0, 5) == 0) begin
         req_ch.valid <= 1'b0;
         repeat ($urandom_range(1, 7)) @(posedge clock);
      end
      req_ch.valid <= 1'b1;
      req_ch.pixel <= px;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      predict_pixel(px);
      pixels_sent++;
   endtask

   task automatic drain();
      req_ch.valid <= 1'b0;
      while (expected_q.size() != 0) @(posedge clock);
      repeat (40) @(posedge clock);
   endtask

   task automatic write_csr(csr_idx_type idx, logic [CSR_DATA_W-1:0] val);
      csr_ch.valid <= 1'b1;
      csr_ch.index <= idx;
      csr_ch.data <= val;
      @(posedge clock);
      while (!csr_ch.ready) @(posedge clock);
      csr_ch.valid <= 1'b0;
      @(posedge clock);
      case (idx)
         CSR_IMAGE_WIDTH: img_w = clamp_val(val, MAXW);
         CSR_IMAGE_HEIGHT: img_h = clamp_val(val, MAXH);
         CSR_WINDOW_HALF: half = clamp_val(val, MAXHALF);
         default: return;
      endcase
      cur_col = 0;
      cur_row = 0;
   endtask

   task automatic setup_frame(int w, int hgt, int hf);
      drain();
      write_csr(CSR_IMAGE_WIDTH, CSR_DATA_W'(w));
      write_csr(CSR_IMAGE_HEIGHT, CSR_DATA_W'(hgt));
      write_csr(CSR_WINDOW_HALF, CSR_DATA_W'(hf));
   endtask

   task automatic send_frame(int mode);
      for (int i = 0; i < img_w * img_h; i++) begin
         case (mode)
            0: send_pixel(8'($urandom));
            1: send_pixel(($urandom_range(0, 1)) ? 8'hff : 8'h00);
            default: send_pixel(8'(i * 37));
         endcase
      end
   endtask

   task automatic test_directed();
      setup_frame(3, 3, 1);
      send_pixel(8'h00); send_pixel(8'hff); send_pixel(8'h55);
      send_pixel(8'haa); send_pixel(8'h80); send_pixel(8'h01);
      send_pixel(8'hfe); send_pixel(8'h7f); send_pixel(8'h10);
      setup_frame(2, 2, 1);
      send_frame(2);
      setup_frame(0, 0, 0);
      send_pixel(8'h42); send_pixel(8'hff);
      setup_frame(5, 4, 2);
      write_csr(CSR_UNUSED, 13'h1fff);
      send_frame(1);
   endtask

   task automatic test_config_extremes();
      setup_frame(13'h1fff, 10, 7);
      for (int i = 0; i < 20; i++) send_pixel(8'($urandom));
      setup_frame(9, 9, 4);
      send_frame(0);
      setup_frame(1024, 3, 1);
      for (int i = 0; i < 40; i++) send_pixel(8'($urandom));
      setup_frame(4, 13'h1fff, 1);
      for (int i = 0; i < 40; i++) send_pixel(8'($urandom));
   endtask

   task automatic test_backpressure();
      setup_frame(6, 6, 1);
      long_hold = 1;
      send_frame(0);
      send_frame(0);
      long_hold = 0;
      drain();
      send_frame(0);
   endtask

   task automatic test_random();
      int n;
      n = 0;
      while (n < 150) begin
         setup_frame($urandom_range(3, 12), $urandom_range(3, 8), $urandom_range(1, 2));
         send_frame($urandom_range(0, 2));
         n += img_w * img_h;
      end
      rsp_idle_en = 0;
      req_idle_en = 0;
      setup_frame(8, 7, 1);
      send_frame(0);
   endtask

   initial begin
      rsp_ch.ready = 1'b0;
      forever begin
         @(posedge clock);
         if (long_hold) begin
            rsp_ch.ready <= 1'b0;
            repeat (300) @(posedge clock);
            long_hold = 0;
         end
         if (rsp_idle_en && $urandom_range(0, 5) == 0) begin
            rsp_ch.ready <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clock);
         end
         rsp_ch.ready <= 1'b1;
      end
   end

   always @(posedge clock) begin
      filt_result_type got, exp_r;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         got = '{rsp_ch.median, rsp_ch.row, rsp_ch.col, rsp_ch.last};
         results_seen++;
         if (expected_q.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected result %p", got);
         end else begin
            exp_r = expected_q.pop_front();
            if (got !== exp_r) begin
               mismatches++;
               if (mismatches <= 10) $display("expected %p got %p", exp_r, got);
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)
          || (csr_ch.valid && csr_ch.ready) || (!req_ch.valid && expected_q.size() == 0))
         idle_count <= 0;
      else
         idle_count <= idle_count + 1;
      if (idle_count >= WD_LIMIT) begin
         $display("window_median_filter_core: mismatch");
         $finish;
      end
   end

   initial begin
      reset = 1'b1;
      req_ch.valid = 1'b0;
      req_ch.pixel = '0;
      csr_ch.valid = 1'b0;
      csr_ch.index = CSR_IMAGE_WIDTH;
      csr_ch.data = '0;
      img_w = 640; img_h = 480; half = 1;
      cur_col = 0; cur_row = 0;
      foreach (lines[k]) lines[k] = '0;
      foreach (win[i, j]) win[i][j] = '0;
      mismatches = 0; results_seen = 0; pixels_sent = 0; idle_count = 0;
      rsp_idle_en = 1; req_idle_en = 1; long_hold = 0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_config_extremes();
      test_backpressure();
      test_random();
      drain();
      if (expected_q.size() != 0) mismatches++;
      $display("covered %0d pixels and %0d filtered results over many frame sizes",
         pixels_sent, results_seen);
      $display("window sizes 3x3 to 9x9, clamped register values and long output stalls");
      if (mismatches == 0)
         $display("window_median_filter_core: match");
      else
         $display("window_median_filter_core: mismatch");
      $finish;
   end
endmodule

// ===== filelist.f =====
+incdir+src
src/wmf_pkg.sv
src/wmf_if.sv
src/wmf_line_store.sv
src/wmf_cell.sv
src/window_median_filter_core.sv
test/wmf_tb_if.sv
test/testbench.sv
